@@ rtl/tdp_pkg.sv @@
`timescale 1ns / 1ps

package tdp_pkg;

  // Width of the payload fields on the ports.
  localparam int FIELD_WIDTH = 32;

  // Width of the number under test; the low bits of the candidate are tested.
  localparam int VALUE_WIDTH = 32;

  // Working width of the datapath: the tested number never exceeds the field.
  localparam int NUM_WIDTH = (VALUE_WIDTH < FIELD_WIDTH) ? VALUE_WIDTH : FIELD_WIDTH;

  // Width of the divider step counter, able to hold NUM_WIDTH itself.
  localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);

  // First trial divisor.
  localparam logic [NUM_WIDTH-1:0] FIRST_DIVISOR = NUM_WIDTH'(2);

  // Sequencer states of the trial loop.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIVIDE,
    ST_DECIDE,
    ST_REPORT
  } tdp_state_t;

endpackage

@@ rtl/tdp_in_if.sv @@
`timescale 1ns / 1ps

// Input channel: one candidate number per item.
interface tdp_in_if;
  logic                           valid;
  logic                           ready;
  logic [tdp_pkg::FIELD_WIDTH-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink (input valid, input candidate, output ready);
endinterface

@@ rtl/tdp_out_if.sv @@
`timescale 1ns / 1ps

// Output channel: the tested number and its primality flag per item.
interface tdp_out_if;
  logic                           valid;
  logic                           ready;
  logic [tdp_pkg::FIELD_WIDTH-1:0] tested_value;
  logic                           prime_flag;

  modport source (output valid, output tested_value, output prime_flag, input ready);
  modport sink (input valid, input tested_value, input prime_flag, output ready);
endinterface

@@ rtl/tdp_divider.sv @@
`timescale 1ns / 1ps

// Restoring divider that retires one quotient bit per cycle.
module tdp_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tdp_pkg::NUM_WIDTH-1:0] dividend,
  input  logic [tdp_pkg::NUM_WIDTH-1:0] divisor,
  output logic                          done,
  output logic [tdp_pkg::NUM_WIDTH-1:0] quotient,
  output logic [tdp_pkg::NUM_WIDTH-1:0] remainder
);
  import tdp_pkg::*;

  logic [NUM_WIDTH-1:0] quo;
  logic [NUM_WIDTH-1:0] rem;
  logic [CNT_WIDTH-1:0] count;
  logic [NUM_WIDTH:0]   shifted;
  logic [NUM_WIDTH:0]   diff;
  logic                 fits;
  logic [NUM_WIDTH-1:0] quo_next;
  logic [NUM_WIDTH-1:0] rem_next;

  // One step: bring down the next dividend bit and try a subtraction.
  always_comb begin
    shifted  = {rem, quo[NUM_WIDTH-1]};
    diff     = shifted - {1'b0, divisor};
    fits     = ~diff[NUM_WIDTH];
    rem_next = fits ? diff[NUM_WIDTH-1:0] : shifted[NUM_WIDTH-1:0];
    quo_next = {quo[NUM_WIDTH-2:0], fits};
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (count == CNT_WIDTH'(1));
      if (start) begin
        count <= CNT_WIDTH'(NUM_WIDTH);
      end else if (count != '0) begin
        count <= count - 1'b1;
      end
    end
  end

  // The quotient register doubles as the dividend shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (count != '0) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

@@ rtl/trial_division_prime_test.sv @@
`timescale 1ns / 1ps

// Trial-division primality test. Each accepted candidate is divided by
// d = 2, 3, 4, ... in a bit-serial restoring divider until either d exceeds
// the quotient (so d*d > n and the number is prime) or a remainder is zero
// (not prime); 0 and 1 are reported as not prime. One result item carries the
// tested number and its flag. Each trial divisor passes through the start,
// divide and decide states of the sequencer. A new candidate is accepted as
// soon as the previous one has moved into the output register, even if that
// result has not yet been taken.
module trial_division_prime_test (
  input  logic         clk,
  input  logic         rst,
  tdp_in_if.sink       operand,
  tdp_out_if.source    result
);
  import tdp_pkg::*;

  tdp_state_t           state;
  tdp_state_t           state_next;
  logic [NUM_WIDTH-1:0] num;
  logic [NUM_WIDTH-1:0] divisor;
  logic                 verdict;
  logic                 div_start;
  logic                 div_done;
  logic [NUM_WIDTH-1:0] quotient;
  logic [NUM_WIDTH-1:0] remainder;
  logic                 take_in;
  logic                 load_out;
  logic                 small_num;
  logic                 bound_passed;
  logic                 out_valid;
  logic [NUM_WIDTH-1:0] out_value;
  logic                 out_flag;

  tdp_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (num),
    .divisor   (divisor),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // Decisions taken from the incoming number and the last division.
  assign small_num    = (operand.candidate[NUM_WIDTH-1:1] == '0);
  assign bound_passed = (divisor > quotient);

  // Next-state logic of the trial loop.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (operand.valid) begin
          state_next = small_num ? ST_REPORT : ST_START;
        end
      end
      ST_START: begin
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (bound_passed || (remainder == '0)) begin
          state_next = ST_REPORT;
        end else begin
          state_next = ST_START;
        end
      end
      ST_REPORT: begin
        if (!out_valid || result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    operand.ready = (state == ST_IDLE);
    div_start     = (state == ST_START);
    load_out      = (state == ST_REPORT) && (!out_valid || result.ready);
  end

  assign take_in = operand.valid && operand.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Number under test, current divisor and the verdict.
  always_ff @(posedge clk) begin
    if (take_in) begin
      num     <= operand.candidate[NUM_WIDTH-1:0];
      divisor <= FIRST_DIVISOR;
      verdict <= 1'b0;
    end else if (state == ST_DECIDE) begin
      verdict <= bound_passed;
      divisor <= divisor + 1'b1;
    end
  end

  // Output register: holds one finished item while the next one is worked on.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value <= num;
      out_flag  <= verdict;
    end
  end

  assign result.valid        = out_valid;
  assign result.tested_value = FIELD_WIDTH'(out_value);
  assign result.prime_flag   = out_flag;

endmodule

@@ rtl/tdp_checker.sv @@
`timescale 1ns / 1ps

// Port-level checks of the primality tester.
module tdp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [tdp_pkg::FIELD_WIDTH-1:0] tested_value,
  input logic                            prime_flag
);
  import tdp_pkg::*;

  logic [2:0] pending;
  logic       in_take;
  logic       out_take;

  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  // Items accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {2'b00, in_take} - {2'b00, out_take};
    end
  end

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // At most one item in work and one in the output register.
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd2)
    else $error("more items in flight than the block can hold");

  // No result appears without an accepted item behind it.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result item without an accepted candidate");

  // Zero, one and even numbers above two are never flagged prime.
  a_trivial_composite: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((tested_value[FIELD_WIDTH-1:1] == '0)
                  || (!tested_value[0] && tested_value != FIELD_WIDTH'(2)))
    |-> !prime_flag)
    else $error("trivially composite number flagged prime");

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (operand.valid),
  .in_ready     (operand.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .tested_value (result.tested_value),
  .prime_flag   (result.prime_flag)
);
